>>> rtl/dtsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_pkg
// Shared types and constants for the decimal text to signed integer parser.
// ----------------------------------------------------------------------------
package dtsi_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MAG_W  = 63;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned WIDE_W = MAG_W + DIG_W;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_FAIL   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              last_char;
  } item_t;

endpackage

>>> rtl/decimal_text_to_signed_int.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_signed_int
// Strict ASCII decimal string to signed 64-bit integer, one character per
// transaction, one result on the transaction that ends the string.
// The last character passes the input register, then the result register.
// Throughput: one character per cycle unless a stalled result holds back
// the last character; x10-and-add accumulation sets the input-to-result path.
// Reset: asynchronous, active low; clears the parse state and both valids.
// ----------------------------------------------------------------------------
module decimal_text_to_signed_int (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dtsi_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            char_present_i,
  input  logic                            last_char_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            parse_ok_o,
  output logic signed [dtsi_pkg::VAL_W-1:0] int_value_o
);
  import dtsi_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_take;

  assign in_item.char_code    = char_code_i;
  assign in_item.char_present = char_present_i;
  assign in_item.last_char    = last_char_i;

  dtsi_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  dtsi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .take_o      (s1_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .parse_ok_o  (parse_ok_o),
    .int_value_o (int_value_o)
  );

endmodule

>>> rtl/dtsi_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_in_reg
// Input register: captures one character transaction and holds it until
// the parse core takes it.
// ----------------------------------------------------------------------------
module dtsi_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dtsi_pkg::item_t in_item_i,
  input  logic          take_i,
  output logic          valid_o,
  output dtsi_pkg::item_t item_o
);
  import dtsi_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/dtsi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_core
// Parse state machine, decimal accumulators and result register.
// ----------------------------------------------------------------------------
module dtsi_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  dtsi_pkg::item_t                item_i,
  output logic                           take_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           parse_ok_o,
  output logic signed [dtsi_pkg::VAL_W-1:0] int_value_o
);
  import dtsi_pkg::*;

  phase_e             phase_q, phase_d;
  logic               minus_q, minus_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [VAL_W-1:0]   neg_q, neg_d;
  logic               res_valid_q, res_valid_d;
  logic               res_ok_q;
  logic [VAL_W-1:0]   res_val_q;

  logic               is_digit, is_blank, is_minus;
  logic [DIG_W-1:0]   digit;
  logic [WIDE_W-1:0]  mag_ext, mag_x10;
  logic [VAL_W-1:0]   neg_x10;
  logic               ovf, add_digit;
  logic               res_ready, go, emit;
  logic               ok_d;
  logic [VAL_W-1:0]   val_d;

  assign is_digit = (item_i.char_code >= CHAR_ZERO) && (item_i.char_code <= CHAR_NINE);
  assign is_blank = (item_i.char_code == CHAR_SPACE) || (item_i.char_code == CHAR_TAB) ||
                    (item_i.char_code == CHAR_LF) || (item_i.char_code == CHAR_CR);
  assign is_minus = (item_i.char_code == CHAR_MINUS);
  assign digit    = item_i.char_code[DIG_W-1:0];

  assign mag_ext  = {{DIG_W{1'b0}}, mag_q};
  assign mag_x10  = (mag_ext << 3) + (mag_ext << 1) + {{MAG_W{1'b0}}, digit};
  assign neg_x10  = (neg_q << 3) + (neg_q << 1) - {{(VAL_W-DIG_W){1'b0}}, digit};
  assign ovf      = |mag_x10[WIDE_W-1:MAG_W];

  assign add_digit = item_i.char_present && is_digit &&
                     ((phase_q == PH_LEAD) || (phase_q == PH_DIGITS));

  assign res_ready = !res_valid_q || !out_stall_i;
  assign go        = valid_i && (!item_i.last_char || res_ready);
  assign emit      = go && item_i.last_char;
  assign take_o    = go;

  always_comb begin
    phase_d = phase_q;
    minus_d = minus_q;
    if (item_i.char_present) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (is_blank) begin
            phase_d = PH_LEAD;
          end else if (is_minus) begin
            minus_d = 1'b1;
            phase_d = PH_DIGITS;
          end else if (is_digit) begin
            phase_d = ovf ? PH_FAIL : PH_DIGITS;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            phase_d = ovf ? PH_FAIL : PH_DIGITS;
          end else if (is_blank) begin
            phase_d = PH_TRAIL;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_TRAIL: begin
          if (!is_blank) begin
            phase_d = PH_FAIL;
          end
        end
        PH_FAIL: begin
          phase_d = PH_FAIL;
        end
        default: begin
          phase_d = PH_FAIL;
        end
      endcase
    end
  end

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    if (add_digit) begin
      if (ovf) begin
        mag_d = '0;
        neg_d = '0;
      end else begin
        mag_d = mag_x10[MAG_W-1:0];
        neg_d = neg_x10;
      end
    end
    ok_d  = (phase_d != PH_FAIL);
    if (!ok_d) begin
      val_d = '0;
    end else if (minus_d) begin
      val_d = neg_d;
    end else begin
      val_d = {1'b0, mag_d};
    end
    res_valid_d = emit || (res_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      minus_q     <= 1'b0;
      mag_q       <= '0;
      neg_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (go) begin
        if (item_i.last_char) begin
          phase_q <= PH_LEAD;
          minus_q <= 1'b0;
          mag_q   <= '0;
          neg_q   <= '0;
        end else begin
          phase_q <= phase_d;
          minus_q <= minus_d;
          mag_q   <= mag_d;
          neg_q   <= neg_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_ok_q  <= ok_d;
      res_val_q <= val_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign parse_ok_o  = res_ok_q;
  assign int_value_o = $signed(res_val_q);

endmodule

>>> rtl/dtsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_checker
// Port-level checks for the decimal text to signed integer parser.
// ----------------------------------------------------------------------------
module dtsi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            parse_ok_o,
  input logic signed [dtsi_pkg::VAL_W-1:0] int_value_o
);
  import dtsi_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(parse_ok_o) && $stable(int_value_o))
    else $error("stalled result transaction changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !parse_ok_o |-> int_value_o == '0)
    else $error("failed parse with nonzero value");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_ok_o |-> int_value_o != $signed(VAL_MIN))
    else $error("value outside signed range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("stalled input transaction withdrawn");

endmodule

bind decimal_text_to_signed_int dtsi_checker u_dtsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .parse_ok_o  (parse_ok_o),
  .int_value_o (int_value_o)
);
